[rtl/core/srcsc_pkg.sv]
// Shared types and constants for the sparse row times CSC matrix core.
// Holds the request and result payload structs, the opcode and queue entry
// types, and the back-end state encoding. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srcsc_pkg;

    localparam int VECTOR_MAX_DEF = 1024;
    localparam int COLUMN_MAX_DEF = 4096;

    localparam int ROW_W   = 10;
    localparam int DATA_W  = 32;
    localparam int VLEN_W  = 11;
    localparam int COL_W   = 12;
    localparam int COUNT_W = 13;

    localparam logic [VLEN_W-1:0]  VLEN_RESET  = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 13'd8191;

    // Entries in the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_WRITE      = 2'd1,
        OP_ENTRY      = 2'd2,
        OP_COLUMN_END = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_WRITE,
        K_COLUMN
    } entry_kind_t;

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } back_state_t;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [ROW_W-1:0]         row_index;
        logic signed [DATA_W-1:0] value;
        logic                     end_of_column;
        logic                     last_column;
    } req_item_t;

    typedef struct packed {
        logic [COL_W-1:0]         column_index;
        logic signed [DATA_W-1:0] product_sum;
        logic                     sum_nonzero;
        logic [COUNT_W-1:0]       nonzero_count;
        logic                     row_error;
        logic                     last;
    } rsp_item_t;

    // A classified request as the back end sees it.
    typedef struct packed {
        entry_kind_t       kind;
        logic [ROW_W-1:0]  addr;
        logic [DATA_W-1:0] value;
        logic              add_en;
        logic              set_err;
        logic              close;
        logic              last;
    } queue_entry_t;

endpackage

`default_nettype wire

[rtl/core/srcsc_front.sv]
// Front end: holds the vector length register, classifies each request and
// buffers it in a short queue for the back end. Depends on srcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srcsc_front #(
    parameter int VECTOR_MAX = srcsc_pkg::VECTOR_MAX_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           req_valid,
    output logic                          req_stall,
    input  wire srcsc_pkg::req_item_t     req_data,
    input  wire                           cfg_write,
    input  wire [srcsc_pkg::VLEN_W-1:0]   cfg_data,
    output logic                          q_valid,
    output srcsc_pkg::queue_entry_t       q_head,
    input  wire                           q_pop
);
    import srcsc_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);

    logic [VLEN_W-1:0] vlen_reg;
    logic [QPW-1:0]    wr_ptr_reg;
    logic [QPW-1:0]    rd_ptr_reg;
    logic [QPW:0]      count_reg;
    queue_entry_t      q_mem_reg [QUEUE_DEPTH];

    queue_entry_t entry;
    logic         useful;
    logic         bad_row;
    logic         push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg <= VLEN_RESET;
        end
        else if (cfg_write)
        begin
            vlen_reg <= cfg_data;
        end
    end

    assign bad_row = ({1'b0, req_data.row_index} >= vlen_reg)
                  || (32'(req_data.row_index) >= 32'(VECTOR_MAX));

    always_comb
    begin
        entry         = '0;
        entry.kind    = K_COLUMN;
        entry.addr    = req_data.row_index;
        entry.value   = req_data.value;
        entry.last    = req_data.last_column;
        useful        = 1'b1;
        unique case (opcode_t'(req_data.opcode))
            OP_CLEAR:
            begin
                entry.kind = K_CLEAR;
            end
            OP_WRITE:
            begin
                entry.kind = K_WRITE;
                // Writes past the end of the store are dropped here.
                useful     = 32'(req_data.row_index) < 32'(VECTOR_MAX);
            end
            OP_ENTRY:
            begin
                entry.add_en  = !bad_row;
                entry.set_err = bad_row;
                entry.close   = req_data.end_of_column;
            end
            OP_COLUMN_END:
            begin
                entry.close = 1'b1;
            end
            default:
            begin
                entry.close = 1'b1;
            end
        endcase
    end

    assign req_stall = (count_reg == (QPW + 1)'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall && useful;
    assign q_valid   = (count_reg != '0);
    assign q_head    = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/srcsc_back.sv]
// Back end: vector store with clearing sweep, multiplier stage, accumulator
// with column bookkeeping and the result register. Depends on srcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srcsc_back #(
    parameter int VECTOR_MAX = srcsc_pkg::VECTOR_MAX_DEF,
    parameter int COLUMN_MAX = srcsc_pkg::COLUMN_MAX_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           q_valid,
    input  wire srcsc_pkg::queue_entry_t  q_head,
    output logic                          q_pop,
    output logic                          rsp_valid,
    input  wire                           rsp_stall,
    output srcsc_pkg::rsp_item_t          rsp_data
);
    import srcsc_pkg::*;

    localparam int AW = $clog2(VECTOR_MAX);
    localparam int CW = $clog2(COLUMN_MAX);

    logic [DATA_W-1:0] vec_mem [VECTOR_MAX];

    back_state_t state_reg;
    back_state_t state_next;
    logic [AW-1:0] sweep_cnt_reg;
    logic [AW-1:0] sweep_cnt_next;
    logic          sweeping;
    logic          sweep_done;

    logic              advance;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] rd_data_reg;

    logic              s2_valid_reg;
    logic [DATA_W-1:0] s2_value_reg;
    logic              s2_add_reg;
    logic              s2_err_reg;
    logic              s2_close_reg;
    logic              s2_last_reg;

    logic              s3_valid_reg;
    logic [DATA_W-1:0] prod_reg;
    logic              s3_add_reg;
    logic              s3_err_reg;
    logic              s3_close_reg;
    logic              s3_last_reg;

    logic [DATA_W-1:0]  acc_reg;
    logic [CW-1:0]      col_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               err_reg;
    logic               rsp_valid_reg;
    rsp_item_t          rsp_data_reg;

    logic [DATA_W-1:0]  acc_sum;
    logic               err_now;
    logic               sum_nz;
    logic [COUNT_W-1:0] cnt_new;
    logic [CW:0]        col_inc;
    logic [CW-1:0]      col_wrap;

    // ---------------------------------------------------------------
    // Store clearing: after reset and on every clear request, zeros are
    // written to one entry per cycle while no request is taken.
    // ---------------------------------------------------------------
    assign sweep_done = (sweep_cnt_reg == AW'(VECTOR_MAX - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (q_pop && (q_head.kind == K_CLEAR))
                begin
                    state_next = ST_SWEEP;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_comb
    begin
        sweeping       = 1'b0;
        sweep_cnt_next = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                sweeping       = 1'b1;
                sweep_cnt_next = sweep_done ? '0 : sweep_cnt_reg + 1'b1;
            end
            ST_RUN:
            begin
                sweeping = 1'b0;
            end
            default:
            begin
                sweeping = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // The whole pipeline moves whenever the result register can take a word.
    assign advance = !rsp_valid_reg || !rsp_stall;
    assign q_pop   = q_valid && advance && !sweeping;

    assign mem_we    = sweeping || (q_pop && (q_head.kind == K_WRITE));
    assign mem_waddr = sweeping ? sweep_cnt_reg : AW'(q_head.addr);
    assign mem_wdata = sweeping ? '0 : q_head.value;
    assign mem_re    = q_pop && (q_head.kind == K_COLUMN);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vec_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= vec_mem[AW'(q_head.addr)];
        end
    end

    // Stage 2 carries the request alongside the store read.
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            s2_value_reg <= q_head.value;
            s2_add_reg   <= q_head.add_en;
            s2_err_reg   <= q_head.set_err;
            s2_close_reg <= q_head.close;
            s2_last_reg  <= q_head.last;
        end
    end

    // Stage 3 holds the product; only its low word is ever used.
    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            prod_reg     <= rd_data_reg * s2_value_reg;
            s3_add_reg   <= s2_add_reg;
            s3_err_reg   <= s2_err_reg;
            s3_close_reg <= s2_close_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= mem_re;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Accumulate and close columns.
    // ---------------------------------------------------------------
    assign acc_sum  = acc_reg + (s3_add_reg ? prod_reg : '0);
    assign err_now  = err_reg || s3_err_reg;
    assign sum_nz   = (acc_sum != '0);
    assign cnt_new  = (sum_nz && (cnt_reg < COUNT_LIMIT)) ? cnt_reg + 1'b1 : cnt_reg;
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign col_wrap = (col_inc >= (CW + 1)'(COLUMN_MAX)) ? '0 : col_inc[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= s3_valid_reg && s3_close_reg;
            if (s3_valid_reg)
            begin
                if (s3_close_reg)
                begin
                    acc_reg <= '0;
                    if (s3_last_reg)
                    begin
                        col_reg <= '0;
                        cnt_reg <= '0;
                        err_reg <= 1'b0;
                    end
                    else
                    begin
                        col_reg <= col_wrap;
                        cnt_reg <= cnt_new;
                        err_reg <= err_now;
                    end
                end
                else
                begin
                    acc_reg <= acc_sum;
                    err_reg <= err_now;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s3_valid_reg && s3_close_reg)
        begin
            rsp_data_reg.column_index  <= COL_W'(col_reg);
            rsp_data_reg.product_sum   <= acc_sum;
            rsp_data_reg.sum_nonzero   <= sum_nz;
            rsp_data_reg.nonzero_count <= cnt_new;
            rsp_data_reg.row_error     <= err_now;
            rsp_data_reg.last          <= s3_last_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

[rtl/core/sparse_row_times_csc_matrix_core.sv]
// A column-closing request passes the queue, the stage 2 store read, the stage 3
// product and the result register. Throughput: one request per cycle while
// req_stall is low; a result per cycle when rsp_stall stays low. A clear request
// holds the back end while the VECTOR_MAX store entries (1024 by default) are swept
// to zero, one entry per cycle. Reset: asynchronous, active low; after it the same
// sweep runs before the first request leaves the queue; cfg_write is always taken.
`timescale 1ns / 1ps
`default_nettype none

module sparse_row_times_csc_matrix_core #(
    parameter int VECTOR_MAX = srcsc_pkg::VECTOR_MAX_DEF,
    parameter int COLUMN_MAX = srcsc_pkg::COLUMN_MAX_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           req_valid,
    output logic                          req_stall,
    input  wire srcsc_pkg::req_item_t     req_data,
    output logic                          rsp_valid,
    input  wire                           rsp_stall,
    output srcsc_pkg::rsp_item_t          rsp_data,
    input  wire                           cfg_write,
    input  wire [srcsc_pkg::VLEN_W-1:0]   cfg_data
);
    import srcsc_pkg::*;

    logic         q_valid;
    logic         q_pop;
    queue_entry_t q_head;

    srcsc_front #(
        .VECTOR_MAX (VECTOR_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    srcsc_back #(
        .VECTOR_MAX (VECTOR_MAX),
        .COLUMN_MAX (COLUMN_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

[rtl/core/srcsc_checker.sv]
// Port-level checks for the sparse row times CSC matrix core, and the bind
// that attaches them to the top level. Depends on srcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srcsc_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         req_valid,
    input wire                         req_stall,
    input wire srcsc_pkg::req_item_t   req_data,
    input wire                         rsp_valid,
    input wire                         rsp_stall,
    input wire srcsc_pkg::rsp_item_t   rsp_data
);

    // A stalled request stays offered and unchanged.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_data))
        else $error("request changed while stalled");

    // A stalled result stays offered and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    a_nonzero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.sum_nonzero == (rsp_data.product_sum != 0)))
        else $error("sum_nonzero disagrees with product_sum");

    // A nonzero sum is counted before it is reported.
    a_count_covers: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.sum_nonzero |-> rsp_data.nonzero_count != 0)
        else $error("nonzero result with zero count");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("result offered during reset");

endmodule

bind sparse_row_times_csc_matrix_core srcsc_checker u_srcsc_checker (.*);

`default_nettype wire

[tb/sparse_row_times_csc_matrix_core_test.sv]
// Self-checking testbench for sparse_row_times_csc_matrix_core: a directed table,
// a long column run and random phases over several vector lengths, scored against
// typed expectations or an in-bench model. Depends on srcsc_pkg and the core RTL.
`timescale 1ns / 1ps

module sparse_row_times_csc_matrix_core_test;

    import srcsc_pkg::*;

    localparam int  CLOCK_HALF_NS    = 2;
    localparam int  RESET_CYCLES     = 5;
    localparam int  ITEMS_PER_PHASE  = 90;
    localparam int  PHASE_COUNT      = 7;
    localparam int  RUN_COLUMNS      = 40;
    localparam int  LONG_HOLD_CYCLES = 150;
    // A clear may still be sweeping the store when the last result arrives.
    localparam int  DRAIN_CYCLES     = VECTOR_MAX_DEF + 16;
    localparam int  DRAIN_LIMIT      = 20000;
    localparam int  REPORT_LIMIT     = 200;
    localparam longint RUN_LIMIT_NS  = 64'd3_000_000;

    localparam rsp_item_t NO_COLUMN = '0;

    typedef struct packed {
        logic              cfg_first;
        logic [VLEN_W-1:0] cfg_value;
        req_item_t         req;
        logic              typed;
        rsp_item_t         rsp;
    } directed_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    req_item_t         req_data;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_item_t         rsp_data;
    logic              cfg_write;
    logic [VLEN_W-1:0] cfg_data;

    // Model state of the core.
    logic [DATA_W-1:0]  vec_model [VECTOR_MAX_DEF];
    logic [DATA_W-1:0]  acc_model;
    logic [COL_W-1:0]   col_model;
    logic [COUNT_W-1:0] nzcount_model;
    logic               err_model;
    logic [VLEN_W-1:0]  vlen_model;

    rsp_item_t     expected_columns [$];
    directed_row_t directed_rows [$];

    bit idle_enable       = 1'b1;
    bit long_hold_request = 1'b0;
    int failures          = 0;
    int items_sent        = 0;
    int clears_sent       = 0;
    int results_checked   = 0;
    int cfg_writes        = 0;

    sparse_row_times_csc_matrix_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(CLOCK_HALF_NS) clk = 1'b1;
        #(CLOCK_HALF_NS) clk = 1'b0;
    end

    function automatic req_item_t make_request(input opcode_t op, input int unsigned row,
                                               input logic [DATA_W-1:0] val,
                                               input bit eoc, input bit lc);
        req_item_t r;
        r.opcode        = op;
        r.row_index     = row[ROW_W-1:0];
        r.value         = val;
        r.end_of_column = eoc;
        r.last_column   = lc;
        return r;
    endfunction

    function automatic rsp_item_t make_column(input int unsigned col,
                                              input logic [DATA_W-1:0] sum,
                                              input bit nz, input int unsigned cnt,
                                              input bit err, input bit lst);
        rsp_item_t c;
        c.column_index  = col[COL_W-1:0];
        c.product_sum   = sum;
        c.sum_nonzero   = nz;
        c.nonzero_count = cnt[COUNT_W-1:0];
        c.row_error     = err;
        c.last          = lst;
        return c;
    endfunction

    // Applies one request to the model state; returns 1 when it closes a column.
    function automatic bit accumulate_request(input req_item_t r, output rsp_item_t res);
        logic [DATA_W-1:0] prod;
        bit                close;
        bit                nz;
        close = 1'b0;
        res   = NO_COLUMN;
        case (r.opcode)
            OP_CLEAR:
                foreach (vec_model[i])
                    vec_model[i] = '0;
            OP_WRITE:
                vec_model[r.row_index] = r.value;
            OP_ENTRY:
            begin
                if ({1'b0, r.row_index} >= vlen_model)
                    err_model = 1'b1;
                else
                begin
                    prod      = vec_model[r.row_index] * $unsigned(r.value);
                    acc_model = acc_model + prod;
                end
                close = r.end_of_column;
            end
            default:
                close = 1'b1;
        endcase
        if (close)
        begin
            nz = (acc_model != '0);
            if (nz && nzcount_model < COUNT_LIMIT)
                nzcount_model = nzcount_model + 1'b1;
            res.column_index  = col_model;
            res.product_sum   = acc_model;
            res.sum_nonzero   = nz;
            res.nonzero_count = nzcount_model;
            res.row_error     = err_model;
            res.last          = r.last_column;
            acc_model = '0;
            if (r.last_column)
            begin
                col_model     = '0;
                nzcount_model = '0;
                err_model     = 1'b0;
            end
            else if (col_model == COL_W'(COLUMN_MAX_DEF - 1))
                col_model = '0;
            else
                col_model = col_model + 1'b1;
        end
        return close;
    endfunction

    function automatic int unsigned pick_row();
        if ($urandom_range(0, 3) != 0)
            return $urandom_range(0, 31);
        return $urandom_range(0, VECTOR_MAX_DEF - 1);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic bit pick_last();
        return ($urandom_range(0, 7) == 0);
    endfunction

    task automatic add_directed(input bit cfg_first, input int unsigned cfg_v,
                                input req_item_t r, input bit typed, input rsp_item_t e);
        directed_row_t row;
        row.cfg_first = cfg_first;
        row.cfg_value = cfg_v[VLEN_W-1:0];
        row.req       = r;
        row.typed     = typed;
        row.rsp       = e;
        directed_rows.push_back(row);
    endtask

    // Offers one request and records its expected column once it is accepted.
    // A typed expectation, when given, replaces the model's one in the queue.
    task automatic send_with_expect(input req_item_t r, input bit typed,
                                    input rsp_item_t typed_rsp);
        int        gap;
        rsp_item_t predicted;
        gap = 0;
        if (idle_enable && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (accumulate_request(r, predicted))
            expected_columns.push_back(typed ? typed_rsp : predicted);
        items_sent++;
        if (r.opcode == OP_CLEAR)
            clears_sent++;
    endtask

    task automatic send_request(input req_item_t r);
        send_with_expect(r, 1'b0, NO_COLUMN);
    endtask

    task automatic end_requests();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_columns.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_vector_length(input int unsigned v);
        end_requests();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v[VLEN_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        vlen_model = v[VLEN_W-1:0];
        cfg_writes++;
    endtask

    // Random traffic: mostly well-formed columns over a small row window,
    // mixed with vector clears and writes, empty columns, open columns and raw noise.
    task automatic send_random(input int count);
        int        target;
        int        sel;
        int        k;
        logic [63:0] raw;
        req_item_t noise;
        target = items_sent + count;
        while (items_sent < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 2)
                send_request(make_request(OP_CLEAR, pick_row(), $urandom,
                                          $urandom_range(0, 1), $urandom_range(0, 1)));
            else if (sel < 20)
                send_request(make_request(OP_WRITE, pick_row(), pick_value(),
                                          $urandom_range(0, 1), $urandom_range(0, 1)));
            else if (sel < 30)
                send_request(make_request(OP_COLUMN_END, $urandom_range(0, VECTOR_MAX_DEF - 1),
                                          $urandom, $urandom_range(0, 1), pick_last()));
            else if (sel < 35)
            begin
                raw   = {$urandom, $urandom};
                noise = raw[$bits(req_item_t)-1:0];
                // Sweeps are slow, so noise never becomes a clear.
                if (noise.opcode == OP_CLEAR)
                    noise.opcode = OP_COLUMN_END;
                send_request(noise);
            end
            else if (sel < 40)
            begin
                k = $urandom_range(1, 3);
                for (int j = 0; j < k; j++)
                    send_request(make_request(OP_ENTRY, pick_row(), pick_value(), 1'b0,
                                              $urandom_range(0, 1)));
            end
            else
            begin
                k = $urandom_range(1, 6);
                for (int j = 0; j < k; j++)
                    send_request(make_request(OP_ENTRY, pick_row(), pick_value(), j == k - 1,
                                              (j == k - 1) ? pick_last()
                                                           : bit'($urandom_range(0, 1))));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t ns: %s mismatch: expected 'h%0h, actual 'h%0h",
                         $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_item_t exp_col;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_columns.size() == 0)
            begin
                failures++;
                $display("%0t ns: column result with none expected: expected nothing, actual %h",
                         $time, rsp_data);
            end
            else
            begin
                exp_col = expected_columns.pop_front();
                check_field("column_index", exp_col.column_index, rsp_data.column_index);
                check_field("product_sum", exp_col.product_sum, rsp_data.product_sum);
                check_field("sum_nonzero", exp_col.sum_nonzero, rsp_data.sum_nonzero);
                check_field("nonzero_count", exp_col.nonzero_count, rsp_data.nonzero_count);
                check_field("row_error", exp_col.row_error, rsp_data.row_error);
                check_field("last", exp_col.last, rsp_data.last);
                results_checked++;
            end
        end
    end

    // Result side back-pressure: short random bursts, plus one long hold-off
    // on request from the stimulus process.
    initial
    begin
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                hold_left         = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                rsp_stall <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(0, 3);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t ns: run exceeded its time limit", $time);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int unsigned   phase_vlen [PHASE_COUNT];
        int            waited;
        directed_row_t row;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_write = 1'b0;
        cfg_data  = '0;

        foreach (vec_model[i])
            vec_model[i] = '0;
        acc_model     = '0;
        col_model     = '0;
        nzcount_model = '0;
        err_model     = 1'b0;
        vlen_model    = VLEN_RESET;

        // Directed table. Vector store contents are tracked in the comments
        // only where a row depends on them.
        add_directed(0, 0, make_request(OP_COLUMN_END, 0, 0, 0, 0), 1,
                     make_column(0, 0, 0, 0, 0, 0));
        add_directed(0, 0, make_request(OP_ENTRY, 0, 7, 1, 0), 1,
                     make_column(1, 0, 0, 0, 0, 0));
        add_directed(0, 0, make_request(OP_WRITE, 0, 32'h7FFF_FFFF, 0, 0), 0, NO_COLUMN);
        add_directed(0, 0, make_request(OP_WRITE, 1023, 32'h8000_0000, 0, 0), 0, NO_COLUMN);
        // Column flags on a write are ignored.
        add_directed(0, 0, make_request(OP_WRITE, 1, 32'hFFFF_FFFF, 1, 1), 0, NO_COLUMN);
        // The largest positive squared wraps to one; last_column without a
        // column end is ignored.
        add_directed(0, 0, make_request(OP_ENTRY, 0, 32'h7FFF_FFFF, 0, 1), 0, NO_COLUMN);
        add_directed(0, 0, make_request(OP_ENTRY, 1023, 32'h8000_0000, 1, 0), 1,
                     make_column(2, 1, 1, 1, 0, 0));
        add_directed(0, 0, make_request(OP_ENTRY, 1, 32'hFFFF_FFFF, 1, 0), 1,
                     make_column(3, 1, 1, 2, 0, 0));
        // An empty column end flushes the open sum.
        add_directed(0, 0, make_request(OP_ENTRY, 1, 1, 0, 0), 0, NO_COLUMN);
        add_directed(0, 0, make_request(OP_COLUMN_END, 0, 0, 0, 0), 1,
                     make_column(4, 32'hFFFF_FFFF, 1, 3, 0, 0));
        add_directed(0, 0, make_request(OP_ENTRY, 0, 0, 1, 0), 1,
                     make_column(5, 0, 0, 3, 0, 0));
        add_directed(0, 0, make_request(OP_ENTRY, 2, 5, 1, 1), 1,
                     make_column(6, 0, 0, 3, 0, 1));
        add_directed(0, 0, make_request(OP_COLUMN_END, 0, 0, 0, 1), 1,
                     make_column(0, 0, 0, 0, 0, 1));
        // The vector store survives a final column.
        add_directed(0, 0, make_request(OP_ENTRY, 0, 1, 0, 0), 0, NO_COLUMN);
        add_directed(0, 0, make_request(OP_ENTRY, 0, 1, 1, 0), 1,
                     make_column(0, 32'hFFFF_FFFE, 1, 1, 0, 0));
        add_directed(0, 0, make_request(OP_CLEAR, 5, 32'hA5A5_A5A5, 1, 1), 0, NO_COLUMN);
        add_directed(0, 0, make_request(OP_ENTRY, 0, 32'hFFFF_FFFF, 1, 0), 1,
                     make_column(1, 0, 0, 1, 0, 0));
        // With one valid element a row of one is out of range and sticks.
        add_directed(1, 1, make_request(OP_WRITE, 0, 3, 0, 0), 0, NO_COLUMN);
        add_directed(0, 0, make_request(OP_ENTRY, 1, 9, 0, 0), 0, NO_COLUMN);
        add_directed(0, 0, make_request(OP_ENTRY, 0, 4, 1, 0), 1,
                     make_column(2, 12, 1, 2, 1, 0));
        add_directed(0, 0, make_request(OP_COLUMN_END, 0, 0, 0, 1), 1,
                     make_column(3, 0, 0, 2, 1, 1));
        add_directed(0, 0, make_request(OP_COLUMN_END, 0, 0, 0, 0), 1,
                     make_column(0, 0, 0, 0, 0, 0));
        // A length of zero rejects every row; the widest length rejects none.
        add_directed(1, 0, make_request(OP_ENTRY, 0, 4, 1, 1), 1,
                     make_column(1, 0, 0, 0, 1, 1));
        add_directed(1, 2047, make_request(OP_WRITE, 1023, 2, 0, 0), 0, NO_COLUMN);
        add_directed(0, 0, make_request(OP_ENTRY, 1023, 3, 1, 0), 1,
                     make_column(0, 6, 1, 1, 0, 0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.cfg_first)
                set_vector_length(row.cfg_value);
            send_with_expect(row.req, row.typed, row.rsp);
        end

        // A stretch of nonfinal columns, each an odd value times one, so every
        // column counts as nonzero.
        send_request(make_request(OP_WRITE, 7, 1, 0, 0));
        send_request(make_request(OP_COLUMN_END, 0, 0, 0, 1));
        for (int i = 0; i < RUN_COLUMNS; i++)
            send_request(make_request(OP_ENTRY, 7, $urandom | 32'd1, 1'b1, 1'b0));
        send_request(make_request(OP_COLUMN_END, 0, 0, 0, 1));

        phase_vlen = '{1024, 1, 0, 2047, 0, 16, 1024};
        phase_vlen[4] = $urandom_range(2, VECTOR_MAX_DEF - 1);
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == PHASE_COUNT - 1)
                idle_enable = 1'b0;
            set_vector_length(phase_vlen[p]);
            send_random(ITEMS_PER_PHASE / 2);
            if (p == 0)
            begin
                // Keep offering while results are held back, so the core fills.
                long_hold_request = 1'b1;
                for (int j = 0; j < 40; j++)
                    send_request(make_request(OP_COLUMN_END, $urandom_range(0, 1023), $urandom,
                                              $urandom_range(0, 1), 1'b0));
            end
            if (p == 3)
            begin
                end_requests();
                wait_results_drained();
            end
            send_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
        end

        end_requests();
        waited = 0;
        while (expected_columns.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_columns.size() != 0)
        begin
            failures++;
            $display("%0t ns: column results missing: expected %0d more, actual 0",
                     $time, expected_columns.size());
        end

        $display("Sent %0d requests (%0d vector clears) over %0d vector length settings,",
                 items_sent, clears_sent, cfg_writes);
        $display("and scored %0d column results with %0d mismatches.",
                 results_checked, failures);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/srcsc_pkg.sv
rtl/core/srcsc_front.sv
rtl/core/srcsc_back.sv
rtl/core/sparse_row_times_csc_matrix_core.sv
rtl/core/srcsc_checker.sv
tb/sparse_row_times_csc_matrix_core_test.sv
